>>> rtl/pps_pkg.sv
// shared types, constants and address helpers for the pwm peptide scorer
// no dependencies; the interfaces, the cell, the mean unit and the top import this package
`default_nettype none

package pps_pkg;

    // table geometry
    localparam int NUM_ALLELES       = 8;
    localparam int NUM_PVALUE_BINS   = 117;
    localparam int NUM_RESIDUE_TYPES = 20;
    localparam int MAX_POS           = 10;
    localparam int MAX_OUT           = 8;

    // one cell per reported allele
    localparam int NUM_CELLS = (NUM_ALLELES < MAX_OUT) ? NUM_ALLELES : MAX_OUT;
    localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int MCNT_W    = $clog2(NUM_CELLS + 1);

    // weight store: table x allele x residue x position
    localparam int ALLELE_STRIDE = NUM_RESIDUE_TYPES * MAX_POS;
    localparam int TABLE_STRIDE  = NUM_ALLELES * ALLELE_STRIDE;
    localparam int WSTORE_DEPTH  = 2 * TABLE_STRIDE;
    localparam int WADDR_W       = $clog2(WSTORE_DEPTH);

    // threshold store: table x bin
    localparam int TSTORE_DEPTH = 2 * NUM_PVALUE_BINS;
    localparam int TADDR_W      = $clog2(TSTORE_DEPTH);
    localparam int JW           = (NUM_PVALUE_BINS > 1) ? $clog2(NUM_PVALUE_BINS) : 1;
    localparam int BIN_W        = $clog2(NUM_PVALUE_BINS + 1);

    // fixed point widths
    localparam int VAL_W   = 24;
    localparam int SUM_W   = 28;
    localparam int ABS_W   = SUM_W - 1;
    localparam int RECIP_W = 28;
    localparam int DIV_SHIFT = ABS_W + 4;

    // reciprocals for truncating division of a magnitude below 2**ABS_W
    localparam logic [RECIP_W-1:0] RECIP_NINE =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9);
    localparam logic [RECIP_W-1:0] RECIP_TEN =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd9) / 64'd10);

    // codes
    localparam logic [1:0] ACT_SCORE  = 2'd0;
    localparam logic [1:0] ACT_WEIGHT = 2'd1;
    localparam logic [1:0] ACT_THRESH = 2'd2;

    localparam logic [3:0] LEN_NINE  = 4'd9;
    localparam logic [3:0] LEN_TEN   = 4'd10;
    localparam logic [3:0] COUNT_MAX = 4'd15;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_NINE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_TEN  = 1'b1;

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [WADDR_W-1:0]      t_waddr;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] length;
        logic [2:0] allele;
        logic [4:0] residue;
        logic [3:0] position;
        logic [6:0] bin;
        t_value     value;
        logic       last;
    } t_in_data;

    typedef struct packed {
        logic [2:0] allele_index;
        t_value     allele_score;
        logic       allele_scored;
        t_value     best_score;
        logic [2:0] best_allele;
        logic [6:0] pvalue_bin;
        logic       valid_res;
        logic       last_of_run;
    } t_out_data;

    typedef struct packed {
        logic add;
        logic drain;
    } t_cell_ctrl;

    typedef struct packed {
        logic valid;
        logic scored;
        logic sel_ten;
        t_sum sum;
    } t_mean_in;

    typedef struct packed {
        logic   valid;
        logic   scored;
        t_value mean;
    } t_mean_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_ADD,
        S_DRAIN,
        S_DIV,
        S_SEARCH,
        S_EMIT
    } t_state;

    function automatic t_waddr f_waddr(input logic tbl, input int unsigned h,
                                       input logic [4:0] res, input logic [3:0] pos);
        f_waddr = WADDR_W'(int'(tbl) * TABLE_STRIDE + int'(h) * ALLELE_STRIDE
                           + int'(res) * MAX_POS + int'(pos));
    endfunction

endpackage

`default_nettype wire

>>> rtl/pps_in_if.sv
// input channel of the pwm peptide scorer: valid, ready and one input item
// depends on pps_pkg
`default_nettype none

interface pps_in_if import pps_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/pps_out_if.sv
// result channel of the pwm peptide scorer: valid, ready and one result item
// depends on pps_pkg
`default_nettype none

interface pps_out_if import pps_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/pps_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/pps_cell.sv
// one allele cell: weight shift stage plus running sum that drains to its neighbor
// depends on pps_pkg
`default_nettype none

module pps_cell import pps_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_value     i_data,
    output t_value          o_data,
    input  wire t_sum       i_sum,
    output t_sum            o_sum
);

    t_value r_data;
    t_sum   r_sum;

    // weight stage shifts every cycle
    always_ff @(posedge i_clk) begin
        r_data <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctrl.add) begin
            r_sum <= r_sum + t_sum'(r_data);
        end else if (i_ctrl.drain) begin
            r_sum <= i_sum;
        end
    end

    assign o_data = r_data;
    assign o_sum  = r_sum;

endmodule

`default_nettype wire

>>> rtl/pps_mean.sv
// three stage mean unit: sum divided by nine or ten, truncated toward zero
// depends on pps_pkg
`default_nettype none

module pps_mean import pps_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mean_in i_in,
    output t_mean_out     o_out
);

    logic                      r_v1, r_sc1, r_sel1, r_neg1;
    logic [ABS_W-1:0]          r_abs1;
    logic                      r_v2, r_sc2, r_neg2;
    logic [VAL_W-1:0]          r_q2;
    logic                      r_v3, r_sc3;
    t_value                    r_mean3;

    logic [RECIP_W-1:0]        w_recip;
    logic [ABS_W+RECIP_W-1:0]  w_prod;
    t_sum                      w_neg_sum;

    assign w_neg_sum = -i_in.sum;
    assign w_recip   = r_sel1 ? RECIP_TEN : RECIP_NINE;
    assign w_prod    = (ABS_W+RECIP_W)'(r_abs1) * (ABS_W+RECIP_W)'(w_recip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        // magnitude and sign
        r_sc1  <= i_in.scored;
        r_sel1 <= i_in.sel_ten;
        r_neg1 <= i_in.sum[SUM_W-1];
        r_abs1 <= i_in.sum[SUM_W-1] ? w_neg_sum[ABS_W-1:0] : i_in.sum[ABS_W-1:0];
        // reciprocal multiply, quotient in the upper bits
        r_sc2  <= r_sc1;
        r_neg2 <= r_neg1;
        r_q2   <= w_prod[DIV_SHIFT +: VAL_W];
        // sign restore, zero when not scored
        r_sc3  <= r_sc2;
        if (!r_sc2) begin
            r_mean3 <= '0;
        end else if (r_neg2) begin
            r_mean3 <= t_value'(~r_q2 + VAL_W'(1));
        end else begin
            r_mean3 <= t_value'(r_q2);
        end
    end

    assign o_out.valid  = r_v3;
    assign o_out.scored = r_sc3;
    assign o_out.mean   = r_mean3;

endmodule

`default_nettype wire

>>> rtl/pwm_peptide_scorer.sv
// pwm peptide scorer: a load or ignored transaction is taken while idle; a scored residue
// runs accept, 8 weight reads one allele per cycle on the weight ram port, wait, add;
// the last residue then drains the allele sums through the mean unit, the mean pipe
// empties, a threshold search (one ram read per bin) may follow, then 8 result transactions
// reset: masks all ones, allele sums and residue count zero; weight and threshold
// stores are undefined until loaded and get no clearing pass
`default_nettype none

module pwm_peptide_scorer import pps_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    pps_in_if.sink                     i_in,
    pps_out_if.source                  o_out
);

    // ---------------------------------------------------------------
    // state and registers
    // ---------------------------------------------------------------
    t_state r_state, n_state;

    logic [CFG_DATA_W-1:0] r_mask9, r_mask10;
    logic [3:0]            r_count;

    // captured scoring transaction
    logic                  r_t;
    logic [4:0]            r_res;
    logic [3:0]            r_pos;
    logic                  r_last;
    logic                  r_pep_ok;
    logic [CFG_DATA_W-1:0] r_mask_sel;

    logic [CELL_W-1:0]     r_h;       // allele being read, counts down
    logic [CELL_W-1:0]     r_drain;   // allele leaving the chain
    logic [CELL_W-1:0]     r_oidx;    // allele being reported

    // means waiting for the summary, allele 0 at the head
    t_value                r_line_mean   [NUM_CELLS];
    logic                  r_line_scored [NUM_CELLS];

    logic [MCNT_W-1:0]     r_mcnt;
    logic                  r_any;
    t_value                r_best;
    logic [CELL_W-1:0]     r_best_h;

    // threshold search pipe
    logic [JW-1:0]         r_j, r_jd;
    logic                  r_dv;
    logic [BIN_W-1:0]      r_pbin;
    logic                  r_valid_res;

    // ---------------------------------------------------------------
    // input decode
    // ---------------------------------------------------------------
    logic       w_in_fire, w_out_fire, w_in_ready, w_out_valid;
    logic       w_table_ok, w_t_sel, w_lookup_ok, w_score_fire;
    logic [3:0] w_count_inc;
    logic       w_wwe, w_twe;
    t_waddr     w_wwaddr, w_wraddr;
    logic [TADDR_W-1:0] w_twaddr, w_traddr;
    logic [VAL_W-1:0]   w_w_rdata, w_thr_rdata;

    assign w_in_fire  = i_in.valid && w_in_ready;
    assign w_out_fire = w_out_valid && o_out.ready;

    assign w_table_ok = (i_in.data.length == LEN_NINE) || (i_in.data.length == LEN_TEN);
    assign w_t_sel    = (i_in.data.length == LEN_TEN);

    assign w_score_fire = w_in_fire && (i_in.data.action == ACT_SCORE);
    assign w_lookup_ok  = w_table_ok && (int'(i_in.data.residue) < NUM_RESIDUE_TYPES)
                          && (r_count < i_in.data.length);
    assign w_count_inc  = (r_count < COUNT_MAX) ? r_count + 4'd1 : r_count;

    // weight load, range checked
    assign w_wwe = w_in_fire && (i_in.data.action == ACT_WEIGHT) && w_table_ok
                   && (int'(i_in.data.allele) < NUM_ALLELES)
                   && (int'(i_in.data.residue) < NUM_RESIDUE_TYPES)
                   && (i_in.data.position < i_in.data.length);
    assign w_wwaddr = f_waddr(w_t_sel, int'(i_in.data.allele), i_in.data.residue,
                              i_in.data.position);

    // threshold load, range checked
    assign w_twe = w_in_fire && (i_in.data.action == ACT_THRESH) && w_table_ok
                   && (int'(i_in.data.bin) < NUM_PVALUE_BINS);
    assign w_twaddr = TADDR_W'(int'(w_t_sel) * NUM_PVALUE_BINS + int'(i_in.data.bin));

    // weight read for the allele under r_h, threshold read for bin r_j
    assign w_wraddr = f_waddr(r_t, int'(r_h), r_res, r_pos);
    assign w_traddr = TADDR_W'(int'(r_t) * NUM_PVALUE_BINS + int'(r_j));

    pps_ram #(.WIDTH(VAL_W), .DEPTH(WSTORE_DEPTH)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_wwe),
        .i_waddr (w_wwaddr),
        .i_wdata (i_in.data.value),
        .i_raddr (w_wraddr),
        .o_rdata (w_w_rdata)
    );

    pps_ram #(.WIDTH(VAL_W), .DEPTH(TSTORE_DEPTH)) u_thresh_ram (
        .i_clk   (i_clk),
        .i_we    (w_twe),
        .i_waddr (w_twaddr),
        .i_wdata (i_in.data.value),
        .i_raddr (w_traddr),
        .o_rdata (w_thr_rdata)
    );

    // ---------------------------------------------------------------
    // cell chain: weights shift toward the tail, reads go tail allele
    // first so that every cell holds its own weight in the add cycle;
    // sums drain toward the head into the mean unit, zeros fill behind
    // ---------------------------------------------------------------
    t_cell_ctrl w_cell_ctrl;
    t_value     w_data [NUM_CELLS];
    t_sum       w_sum  [NUM_CELLS];

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        t_value w_cin;
        t_sum   w_sin;

        if (k == 0) begin : g_head
            assign w_cin = t_value'(w_w_rdata);
        end else begin : g_body
            assign w_cin = w_data[k-1];
        end

        if (k == NUM_CELLS - 1) begin : g_tail
            assign w_sin = '0;
        end else begin : g_inner
            assign w_sin = w_sum[k+1];
        end

        pps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_cell_ctrl),
            .i_data  (w_cin),
            .o_data  (w_data[k]),
            .i_sum   (w_sin),
            .o_sum   (w_sum[k])
        );
    end

    // ---------------------------------------------------------------
    // mean unit
    // ---------------------------------------------------------------
    t_mean_in  w_mean_in;
    t_mean_out w_mean;
    logic      w_mean_valid;

    assign w_mean_in.valid   = w_mean_valid;
    assign w_mean_in.scored  = r_pep_ok && r_mask_sel[r_drain];
    assign w_mean_in.sel_ten = r_t;
    assign w_mean_in.sum     = w_sum[0];

    pps_mean u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (w_mean_in),
        .o_out   (w_mean)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    logic w_div_done, w_hit, w_search_done;

    assign w_div_done    = (r_state == S_DIV) && (r_mcnt == MCNT_W'(NUM_CELLS));
    assign w_hit         = r_dv && (r_best > t_value'(w_thr_rdata));
    assign w_search_done = r_dv && (w_hit || (r_jd == JW'(NUM_PVALUE_BINS - 1)));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_score_fire) begin
                    if (w_lookup_ok) begin
                        n_state = S_READ;
                    end else if (i_in.data.last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_READ: begin
                if (r_h == CELL_W'(0)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                n_state = r_last ? S_DRAIN : S_IDLE;
            end
            S_DRAIN: begin
                if (r_drain == CELL_W'(NUM_CELLS - 1)) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = (r_pep_ok && r_any) ? S_SEARCH : S_EMIT;
                end
            end
            S_SEARCH: begin
                if (w_search_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_fire && (r_oidx == CELL_W'(NUM_CELLS - 1))) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready        = 1'b0;
        w_out_valid       = 1'b0;
        w_cell_ctrl.add   = 1'b0;
        w_cell_ctrl.drain = 1'b0;
        w_mean_valid      = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
            end
            S_ADD: begin
                w_cell_ctrl.add = 1'b1;
            end
            S_DRAIN: begin
                w_cell_ctrl.drain = 1'b1;
                w_mean_valid      = 1'b1;
            end
            S_EMIT: begin
                w_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask9  <= '1;
            r_mask10 <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MASK_NINE: r_mask9  <= i_cfg_data;
                CFG_MASK_TEN:  r_mask10 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // residue count, cleared by the last residue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_score_fire) begin
            r_count <= i_in.data.last ? 4'd0 : w_count_inc;
        end
    end

    // capture of the scoring transaction; the length on the last residue
    // decides table, masks and the count check
    always_ff @(posedge i_clk) begin
        if (w_score_fire) begin
            r_t        <= w_t_sel;
            r_res      <= i_in.data.residue;
            r_pos      <= r_count;
            r_last     <= i_in.data.last;
            r_pep_ok   <= w_table_ok && (w_count_inc == i_in.data.length);
            r_mask_sel <= w_t_sel ? r_mask10 : r_mask9;
        end
    end

    // read, drain and report counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= '0;
            r_drain <= '0;
            r_oidx  <= '0;
        end else begin
            if (w_score_fire) begin
                r_h <= CELL_W'(NUM_CELLS - 1);
            end else if (r_state == S_READ) begin
                r_h <= r_h - CELL_W'(1);
            end

            if (r_state == S_DRAIN) begin
                r_drain <= r_drain + CELL_W'(1);
            end else begin
                r_drain <= '0;
            end

            if (r_state != S_EMIT) begin
                r_oidx <= '0;
            end else if (w_out_fire) begin
                r_oidx <= r_oidx + CELL_W'(1);
            end
        end
    end

    // best allele in ascending order, strict greater keeps the first on a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_state == S_IDLE)) begin
            r_mcnt   <= '0;
            r_any    <= 1'b0;
            r_best   <= '0;
            r_best_h <= '0;
        end else if (w_mean.valid) begin
            r_mcnt <= r_mcnt + MCNT_W'(1);
            if (w_mean.scored && (!r_any || (w_mean.mean > r_best))) begin
                r_best   <= w_mean.mean;
                r_best_h <= CELL_W'(r_mcnt);
                r_any    <= 1'b1;
            end
        end
    end

    // mean line fills at the tail, results leave from the head
    always_ff @(posedge i_clk) begin
        if (w_mean.valid || w_out_fire) begin
            for (int k = 0; k < NUM_CELLS - 1; k++) begin
                r_line_mean[k]   <= r_line_mean[k+1];
                r_line_scored[k] <= r_line_scored[k+1];
            end
            if (w_mean.valid) begin
                r_line_mean[NUM_CELLS-1]   <= w_mean.mean;
                r_line_scored[NUM_CELLS-1] <= w_mean.scored;
            end
        end
    end

    // threshold search, one bin per cycle, first bin below the best wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_state != S_SEARCH)) begin
            r_j  <= '0;
            r_dv <= 1'b0;
        end else begin
            r_dv <= 1'b1;
            if (r_j != JW'(NUM_PVALUE_BINS - 1)) begin
                r_j <= r_j + JW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_jd <= r_j;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbin      <= '0;
            r_valid_res <= 1'b0;
        end else begin
            if (w_div_done) begin
                r_pbin      <= '0;
                r_valid_res <= r_pep_ok && r_any;
            end else if ((r_state == S_SEARCH) && w_search_done) begin
                // no bin below the best means p equals one
                r_pbin <= w_hit ? BIN_W'(r_jd) : BIN_W'(NUM_PVALUE_BINS);
            end
        end
    end

    // ---------------------------------------------------------------
    // result transaction
    // ---------------------------------------------------------------
    assign i_in.ready                 = w_in_ready;
    assign o_out.valid                = w_out_valid;
    assign o_out.data.allele_index    = 3'(r_oidx);
    assign o_out.data.allele_score    = r_line_mean[0];
    assign o_out.data.allele_scored   = r_line_scored[0];
    assign o_out.data.best_score      = r_best;
    assign o_out.data.best_allele     = 3'(r_best_h);
    assign o_out.data.pvalue_bin      = 7'(r_pbin);
    assign o_out.data.valid_res       = r_valid_res;
    assign o_out.data.last_of_run     = (r_oidx == CELL_W'(NUM_CELLS - 1));

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_cleared_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && o_out.data.last_of_run) |=> (r_state == S_IDLE && w_sum[0] == '0))
        else $error("sums not cleared or block not idle after last result");

    a_mean_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcnt <= MCNT_W'(NUM_CELLS))
        else $error("more means collected than cells");

    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.pvalue_bin <= 7'(NUM_PVALUE_BINS)))
        else $error("p-value bin out of range");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.valid_res) |->
            (o_out.data.best_score == '0 && !o_out.data.allele_scored
             && o_out.data.pvalue_bin == '0))
        else $error("invalid result carries a score");

endmodule

`default_nettype wire
